// ===== hdl/afs_pkg.sv =====
package afs_pkg;

    // Operation codes carried by an input beat.
    localparam logic [1:0] OP_TIME = 2'd0;
    localparam logic [1:0] OP_CTRL = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_REPEAT      = 2'd1;
    localparam logic [1:0] CFG_LOOP        = 2'd2;
    localparam logic [1:0] CFG_TICK_SCALE  = 2'd3;

    // Button bit positions.
    localparam int BTN_PLAY     = 0;
    localparam int BTN_RESTART  = 1;
    localparam int BTN_BACK     = 2;
    localparam int BTN_FWD      = 3;
    localparam int BTN_BACK_HLD = 4;
    localparam int BTN_FWD_HLD  = 5;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PS_STOPPED  = 2'd0,
        PS_PLAYING  = 2'd1,
        PS_COMPLETE = 2'd2
    } play_state_t;

    typedef enum logic [1:0] {
        CMD_TIME,
        CMD_CTRL,
        CMD_LOAD,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] tick_count;
        logic [5:0]  buttons;
        logic [7:0]  frame_slot;
        logic [7:0]  delay_value;
    } in_item_t;

    typedef struct packed {
        logic        show_frame;
        logic [7:0]  frame_number;
        logic [1:0]  player_state;
        logic [7:0]  loops_done;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] ticks;
        logic [5:0]  buttons;
        logic [7:0]  slot;
        logic [7:0]  delay;
    } cmd_t;

    typedef struct packed {
        logic [8:0]  frame_count;
        logic [7:0]  repeat_count;
        logic        loop_forever;
        logic [15:0] ticks_per_delay_unit;
    } cfg_t;

endpackage

// ===== hdl/afs_front.sv =====
module afs_front #(
    parameter int MAX_FRAMES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  afs_pkg::in_item_t in_data,
    input  logic             q_full,
    output logic             push,
    output afs_pkg::cmd_t    push_cmd
);

    logic          front_valid_reg;
    logic          front_valid_next;
    afs_pkg::cmd_t cmd_reg;
    afs_pkg::cmd_t cmd_next;

    // The stage holds its beat only while the queue is full.
    assign in_stall = front_valid_reg & q_full;
    assign push     = front_valid_reg & ~q_full;
    assign push_cmd = cmd_reg;

    // Classify the incoming beat; loads to a slot beyond the table become no-ops.
    always_comb
    begin
        cmd_next.ticks   = in_data.tick_count;
        cmd_next.buttons = in_data.buttons;
        cmd_next.slot    = in_data.frame_slot;
        cmd_next.delay   = in_data.delay_value;
        unique case (in_data.operation)
            afs_pkg::OP_TIME: cmd_next.kind = afs_pkg::CMD_TIME;
            afs_pkg::OP_CTRL: cmd_next.kind = afs_pkg::CMD_CTRL;
            afs_pkg::OP_LOAD:
            begin
                if (32'(in_data.frame_slot) < 32'(MAX_FRAMES))
                    cmd_next.kind = afs_pkg::CMD_LOAD;
                else
                    cmd_next.kind = afs_pkg::CMD_NOP;
            end
            afs_pkg::OP_NONE: cmd_next.kind = afs_pkg::CMD_NOP;
            default:          cmd_next.kind = afs_pkg::CMD_NOP;
        endcase
    end

    assign front_valid_next = in_stall ? front_valid_reg : in_valid;

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            cmd_reg <= cmd_next;
    end

endmodule

// ===== hdl/afs_queue.sv =====
module afs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  afs_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output afs_pkg::cmd_t head
);

    localparam int PTR_W = (afs_pkg::QUEUE_DEPTH > 1) ? $clog2(afs_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(afs_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(afs_pkg::QUEUE_DEPTH - 1);

    afs_pkg::cmd_t    entry_reg [afs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(afs_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== hdl/afs_back.sv =====
module afs_back #(
    parameter int MAX_FRAMES  = 256,
    parameter int DELAY_WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  afs_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    input  afs_pkg::cmd_t      cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output afs_pkg::out_item_t out_data
);

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int FC_W   = CNT_W + 9;
    localparam int PROD_W = DELAY_WIDTH + 16;

    afs_pkg::play_state_t state_reg;
    afs_pkg::play_state_t state_next;
    logic [IDX_W-1:0]     frame_reg;
    logic [IDX_W-1:0]     frame_next;
    logic [31:0]          elapsed_reg;
    logic [31:0]          elapsed_next;
    logic [7:0]           loops_reg;
    logic [7:0]           loops_next;
    logic                 shown_next;

    logic [DELAY_WIDTH-1:0] delay_mem [MAX_FRAMES];
    logic [DELAY_WIDTH-1:0] delay_reg;
    logic [DELAY_WIDTH-1:0] load_delay;
    logic [15:0]            load_wide;
    logic [IDX_W-1:0]       load_addr;
    logic [IDX_W+7:0]       slot_wide;
    logic                   load_en;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    afs_pkg::out_item_t   out_reg;
    afs_pkg::out_item_t   out_next;

    logic [FC_W-1:0]      fc_wide;
    logic [FC_W-1:0]      eff_wide;
    logic [CNT_W-1:0]     eff_count;
    logic                 fire;

    // Effective frame count is the register clamped to one up to the table size.
    assign fc_wide = FC_W'(cfg.frame_count);
    always_comb
    begin
        priority if (fc_wide == '0)
            eff_wide = FC_W'(1);
        else if (fc_wide > FC_W'(MAX_FRAMES))
            eff_wide = FC_W'(MAX_FRAMES);
        else
            eff_wide = fc_wide;
    end
    assign eff_count = eff_wide[CNT_W-1:0];

    // A command executes when the result register is free or being emptied.
    assign fire = cmd_valid & (~out_valid_reg | ~out_stall);
    assign pop  = fire;

    // Next player state from the command at the head of the queue.
    always_comb
    begin
        logic [32:0]       el_sum;
        logic [31:0]       el_sat;
        logic [PROD_W-1:0] thr;
        logic [CNT_W-1:0]  cur_p1;
        logic [7:0]        lc_inc;
        logic              step_ok;

        state_next   = state_reg;
        frame_next   = frame_reg;
        elapsed_next = elapsed_reg;
        loops_next   = loops_reg;
        shown_next   = 1'b0;
        step_ok      = 1'b0;

        el_sum = {1'b0, elapsed_reg} + 33'(cmd.ticks);
        el_sat = el_sum[32] ? '1 : el_sum[31:0];
        thr    = PROD_W'(delay_reg) * PROD_W'(cfg.ticks_per_delay_unit);
        cur_p1 = CNT_W'(frame_reg) + 1'b1;
        lc_inc = (loops_reg == 8'hFF) ? loops_reg : loops_reg + 1'b1;

        if (fire)
        begin
            unique case (cmd.kind)
                afs_pkg::CMD_TIME:
                begin
                    if (state_reg == afs_pkg::PS_PLAYING)
                    begin
                        elapsed_next = el_sat;
                        if (el_sat >= 32'(thr))
                        begin
                            if (cur_p1 >= eff_count)
                            begin
                                if (!cfg.loop_forever)
                                    loops_next = lc_inc;
                                if (!cfg.loop_forever && (lc_inc >= cfg.repeat_count))
                                begin
                                    state_next = afs_pkg::PS_COMPLETE;
                                end
                                else
                                begin
                                    frame_next   = '0;
                                    elapsed_next = '0;
                                    shown_next   = 1'b1;
                                end
                            end
                            else
                            begin
                                frame_next   = cur_p1[IDX_W-1:0];
                                elapsed_next = '0;
                                shown_next   = 1'b1;
                            end
                        end
                    end
                end
                afs_pkg::CMD_CTRL:
                begin
                    // Play and pause swap; a completed player ignores it.
                    if (cmd.buttons[afs_pkg::BTN_PLAY])
                    begin
                        if (state_next == afs_pkg::PS_PLAYING)
                            state_next = afs_pkg::PS_STOPPED;
                        else if (state_next == afs_pkg::PS_STOPPED)
                            state_next = afs_pkg::PS_PLAYING;
                    end
                    if (cmd.buttons[afs_pkg::BTN_RESTART])
                    begin
                        frame_next   = '0;
                        elapsed_next = '0;
                        shown_next   = 1'b1;
                        state_next   = afs_pkg::PS_PLAYING;
                    end
                    // Steps in button order: back, forward, back held, forward held.
                    for (int k = afs_pkg::BTN_BACK; k <= afs_pkg::BTN_FWD_HLD; k++)
                    begin
                        if (cmd.buttons[k])
                        begin
                            if ((k % 2) == 1)
                                step_ok = (CNT_W'(frame_next) + 1'b1) < eff_count;
                            else
                                step_ok = (frame_next != '0);
                            if (step_ok)
                            begin
                                if ((k % 2) == 1)
                                    frame_next = frame_next + 1'b1;
                                else
                                    frame_next = frame_next - 1'b1;
                                elapsed_next = '0;
                                shown_next   = 1'b1;
                                if (state_next == afs_pkg::PS_COMPLETE)
                                    state_next = afs_pkg::PS_STOPPED;
                            end
                        end
                    end
                end
                afs_pkg::CMD_LOAD: ;
                afs_pkg::CMD_NOP:  ;
                default: ;
            endcase
        end
    end

    // Result beat built from the updated state.
    always_comb
    begin
        slot_wide             = {8'd0, frame_next};
        out_next.show_frame   = shown_next;
        out_next.frame_number = slot_wide[7:0];
        out_next.player_state = state_next;
        out_next.loops_done   = loops_next;
    end

    assign out_valid_next = fire | (out_valid_reg & out_stall);
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;

    // Player state and result flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= afs_pkg::PS_STOPPED;
            frame_reg     <= '0;
            elapsed_reg   <= '0;
            loops_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            elapsed_reg   <= elapsed_next;
            loops_reg     <= loops_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= out_next;
    end

    // Delay table write data, sized to the table width.
    assign load_en    = fire & (cmd.kind == afs_pkg::CMD_LOAD);
    assign load_wide  = {8'd0, cmd.delay};
    assign load_delay = load_wide[DELAY_WIDTH-1:0];
    assign load_addr  = IDX_W'(cmd.slot);

    // The table is read at the next frame so the delay register always
    // holds the delay of the current frame; a load to that frame bypasses.
    always_ff @(posedge clk)
    begin
        if (load_en)
            delay_mem[load_addr] <= load_delay;
        if (load_en && (load_addr == frame_next))
            delay_reg <= load_delay;
        else
            delay_reg <= delay_mem[frame_next];
    end

endmodule

// ===== hdl/animation_frame_sequencer.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data (afs_pkg::in_item_t)
// out       output     out_valid/out_stall  out_data (afs_pkg::out_item_t)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low; its result passes the
// decode stage, the command queue and the result register before out_valid.
// The time step needs one 8 by 16 bit multiply, a 32-bit saturating add and
// a compare in the execute cycle; the delay of the current frame is always
// ready in a register, read from the table at the next frame address.
// Reset clears the player state and the queue and returns the configuration
// to its defaults; the delay table is not cleared. A stalled output fills the
// queue, after which in_stall rises.
module animation_frame_sequencer #(
    parameter int MAX_FRAMES  = 256,
    parameter int DELAY_WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  afs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output afs_pkg::out_item_t out_data,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    afs_pkg::cfg_t cfg_reg;
    afs_pkg::cfg_t cfg_next;
    logic          q_full;
    logic          q_push;
    afs_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    logic          q_not_empty;
    afs_pkg::cmd_t q_head;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                afs_pkg::CFG_FRAME_COUNT: cfg_next.frame_count          = cfg_data[8:0];
                afs_pkg::CFG_REPEAT:      cfg_next.repeat_count         = cfg_data[7:0];
                afs_pkg::CFG_LOOP:        cfg_next.loop_forever         = cfg_data[0];
                afs_pkg::CFG_TICK_SCALE:  cfg_next.ticks_per_delay_unit = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count          <= 9'd1;
            cfg_reg.repeat_count         <= 8'd0;
            cfg_reg.loop_forever         <= 1'b1;
            cfg_reg.ticks_per_delay_unit <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    afs_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    afs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    afs_back #(
        .MAX_FRAMES  (MAX_FRAMES),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_FRAMES      = 256;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    afs_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    afs_pkg::out_item_t out_data;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = afs_pkg::CFG_FRAME_COUNT;
    logic [15:0]        cfg_data  = '0;

    animation_frame_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Beats waiting to be driven and player status still owed by the block.
    afs_pkg::in_item_t    beats_to_send [$];
    afs_pkg::out_item_t   status_due [$];
    afs_pkg::out_item_t   want_status;
    idle_mode_t           idle_mode = IDLE_NONE;

    // Own copy of the player, its delay table and its registers.
    afs_pkg::cfg_t        cfg = '{9'd1, 8'd0, 1'b1, 16'd1};
    afs_pkg::play_state_t player = afs_pkg::PS_STOPPED;
    logic [7:0]           frame_idx = '0;
    logic [31:0]          elapsed = '0;
    logic [7:0]           loops = '0;
    logic [7:0]           delay_tab [MAX_FRAMES];
    logic                 frame_shown;

    int failures      = 0;
    int beats_in      = 0;
    int results_out   = 0;
    int frames_seen   = 0;
    int complete_seen = 0;
    int loops_peak    = 0;
    int phases_run    = 0;
    int quiet_cycles  = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Frame count as the player sees it, clamped to the table size.
    function automatic int frames_in_use();
        if (cfg.frame_count == 0)
            return 1;
        if (cfg.frame_count > MAX_FRAMES)
            return MAX_FRAMES;
        return cfg.frame_count;
    endfunction

    // A frame start clears the elapsed time and releases a completed player.
    function automatic void start_frame(int idx);
        frame_idx = idx[7:0];
        elapsed = '0;
        if (player == afs_pkg::PS_COMPLETE)
            player = afs_pkg::PS_STOPPED;
        frame_shown = 1'b1;
    endfunction

    function automatic void step_frame(bit forward);
        if (forward)
        begin
            if (frame_idx + 1 < frames_in_use())
                start_frame(frame_idx + 1);
        end
        else if (frame_idx != 0)
            start_frame(frame_idx - 1);
    endfunction

    function automatic void pass_time(logic [15:0] ticks);
        logic [32:0] sum;
        logic [23:0] threshold;
        int          next_idx;
        if (player != afs_pkg::PS_PLAYING)
            return;
        sum = {1'b0, elapsed} + ticks;
        elapsed = sum[32] ? '1 : sum[31:0];
        threshold = delay_tab[frame_idx] * cfg.ticks_per_delay_unit;
        if (elapsed < {8'd0, threshold})
            return;
        next_idx = frame_idx + 1;
        if (next_idx >= frames_in_use())
        begin
            // End of a pass: a finite animation counts it and may complete.
            if (!cfg.loop_forever)
            begin
                if (loops != 8'hFF)
                    loops++;
                if (loops >= cfg.repeat_count)
                begin
                    player = afs_pkg::PS_COMPLETE;
                    return;
                end
            end
            next_idx = 0;
        end
        start_frame(next_idx);
    endfunction

    // Buttons act in a fixed order: play/pause, restart, then the four steps.
    function automatic void press_buttons(logic [5:0] b);
        if (b[afs_pkg::BTN_PLAY])
        begin
            if (player == afs_pkg::PS_PLAYING)
                player = afs_pkg::PS_STOPPED;
            else if (player == afs_pkg::PS_STOPPED)
                player = afs_pkg::PS_PLAYING;
        end
        if (b[afs_pkg::BTN_RESTART])
        begin
            start_frame(0);
            player = afs_pkg::PS_PLAYING;
        end
        if (b[afs_pkg::BTN_BACK])
            step_frame(1'b0);
        if (b[afs_pkg::BTN_FWD])
            step_frame(1'b1);
        if (b[afs_pkg::BTN_BACK_HLD])
            step_frame(1'b0);
        if (b[afs_pkg::BTN_FWD_HLD])
            step_frame(1'b1);
    endfunction

    function automatic afs_pkg::out_item_t predict_status(afs_pkg::in_item_t beat);
        afs_pkg::out_item_t status;
        frame_shown = 1'b0;
        case (beat.operation)
            afs_pkg::OP_TIME: pass_time(beat.tick_count);
            afs_pkg::OP_CTRL: press_buttons(beat.buttons);
            afs_pkg::OP_LOAD: delay_tab[beat.frame_slot] = beat.delay_value;
            default: ;
        endcase
        status.show_frame   = frame_shown;
        status.frame_number = frame_idx;
        status.player_state = player;
        status.loops_done   = loops;
        return status;
    endfunction

    function automatic afs_pkg::in_item_t make_item(logic [1:0] op, int ticks, int buttons,
                                                    int slot, int delay);
        afs_pkg::in_item_t beat;
        beat.operation   = op;
        beat.tick_count  = ticks[15:0];
        beat.buttons     = buttons[5:0];
        beat.frame_slot  = slot[7:0];
        beat.delay_value = delay[7:0];
        return beat;
    endfunction

    // Random beat; fields the operation ignores carry random junk.
    function automatic afs_pkg::in_item_t random_item(int max_delay, int max_tick,
                                                      int time_pct);
        afs_pkg::in_item_t beat;
        int                pick;
        int                rest;
        int                roll;
        beat.tick_count  = 16'($urandom);
        beat.buttons     = 6'($urandom);
        beat.frame_slot  = 8'($urandom);
        beat.delay_value = 8'($urandom);
        pick = $urandom_range(0, 99);
        rest = 100 - time_pct;
        if (pick < time_pct)
        begin
            beat.operation = afs_pkg::OP_TIME;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                beat.tick_count = '0;
            else if (roll == 1)
                beat.tick_count = '1;
            else
                beat.tick_count = 16'($urandom_range(0, max_tick));
        end
        else if (pick < time_pct + rest * 6 / 10)
        begin
            beat.operation = afs_pkg::OP_CTRL;
            if ($urandom_range(0, 1) == 1)
                beat.buttons = 6'(1 << $urandom_range(0, 5));
        end
        else if (pick < time_pct + rest * 9 / 10)
        begin
            beat.operation   = afs_pkg::OP_LOAD;
            beat.delay_value = 8'($urandom_range(0, max_delay));
            if ($urandom_range(0, 1) == 1)
                beat.frame_slot = 8'($urandom_range(0, 15));
        end
        else
            beat.operation = afs_pkg::OP_NONE;
        return beat;
    endfunction

    function automatic bit idle_roll(bit sender_side);
        int pct;
        case (idle_mode)
            IDLE_SENDER:   pct = sender_side ? 84 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 84;
            IDLE_BOTH:     pct = 20;
            default:       pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got)
        begin
            failures++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        case (idx)
            afs_pkg::CFG_FRAME_COUNT: cfg.frame_count          = value[8:0];
            afs_pkg::CFG_REPEAT:      cfg.repeat_count         = value[7:0];
            afs_pkg::CFG_LOOP:        cfg.loop_forever         = value[0];
            afs_pkg::CFG_TICK_SCALE:  cfg.ticks_per_delay_unit = value[15:0];
            default: ;
        endcase
    endtask

    // Registers are only written while the block holds no work.
    task automatic configure(int frames, int repeats, int forever_loop, int scale,
                             idle_mode_t mode);
        write_reg(afs_pkg::CFG_FRAME_COUNT, frames);
        write_reg(afs_pkg::CFG_REPEAT, repeats);
        write_reg(afs_pkg::CFG_LOOP, forever_loop);
        write_reg(afs_pkg::CFG_TICK_SCALE, scale);
        @(posedge clk);
        cfg_write <= 1'b0;
        idle_mode = mode;
        phases_run++;
    endtask

    task automatic queue_random(int count, int max_delay, int max_tick, int time_pct);
        repeat (count)
            beats_to_send.push_back(random_item(max_delay, max_tick, time_pct));
    endtask

    task automatic drain();
        while (beats_to_send.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Driver: offers the next beat once the previous one has gone, unless it idles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                status_due.push_back(predict_status(in_data));
                beats_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (beats_to_send.size() != 0 && !idle_roll(1'b1))
                begin
                    in_valid <= 1'b1;
                    in_data  <= beats_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output stall: a requested long hold-off first, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_req)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            hold_seen <= hold_seen + 1;
        end
        else
            out_stall <= idle_roll(1'b0);
    end

    // Monitor: each result beat against the oldest expected status.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_out++;
            if (status_due.size() == 0)
            begin
                failures++;
                $error("result beat arrived with no status expected");
            end
            else
            begin
                want_status = status_due.pop_front();
                check_field("show_frame", want_status.show_frame, out_data.show_frame);
                check_field("frame_number", want_status.frame_number, out_data.frame_number);
                check_field("player_state", want_status.player_state, out_data.player_state);
                check_field("loops_done", want_status.loops_done, out_data.loops_done);
            end
            if (out_data.show_frame)
                frames_seen++;
            if (out_data.player_state == afs_pkg::PS_COMPLETE)
                complete_seen++;
            if (out_data.loops_done > loops_peak)
                loops_peak = out_data.loops_done;
        end
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every delay entry is written before any frame can be timed.
        for (int slot = 0; slot < MAX_FRAMES; slot++)
            beats_to_send.push_back(make_item(afs_pkg::OP_LOAD, $urandom, $urandom, slot,
                                              $urandom_range(0, 40)));
        drain();

        // Directed: three frames, one pass, then the buttons one by one and all at once.
        configure(3, 1, 0, 1, IDLE_NONE);
        beats_to_send.push_back(make_item(afs_pkg::OP_LOAD, 0, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_LOAD, 0, 0, 1, 255));
        beats_to_send.push_back(make_item(afs_pkg::OP_LOAD, 0, 0, 2, 2));
        beats_to_send.push_back(make_item(afs_pkg::OP_LOAD, 0, 0, 255, 255));
        beats_to_send.push_back(make_item(afs_pkg::OP_NONE, 65535, 63, 255, 255));
        beats_to_send.push_back(make_item(afs_pkg::OP_TIME, 65535, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0, 1 << afs_pkg::BTN_PLAY, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_TIME, 0, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_TIME, 65535, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_TIME, 1, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_TIME, 1, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0, 1 << afs_pkg::BTN_PLAY, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_TIME, 65535, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0, 1 << afs_pkg::BTN_BACK, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0,
                                          1 << afs_pkg::BTN_FWD_HLD, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0, 1 << afs_pkg::BTN_FWD, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0,
                                          1 << afs_pkg::BTN_RESTART, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0, 63, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0,
                                          1 << afs_pkg::BTN_BACK_HLD, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0, 1 << afs_pkg::BTN_PLAY, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_TIME, 0, 0, 0, 0));
        drain();

        // Random phases across register settings and idling patterns.
        configure(4, 3, 0, 1, IDLE_NONE);
        queue_random(150, 8, 12, 55);
        drain();

        configure(256, 0, 1, 65535, IDLE_SENDER);
        queue_random(150, 2, 65535, 55);
        drain();

        // Zero tick scale; frame count lowered below the frame just shown.
        configure(6, 20, 0, 0, IDLE_RECEIVER);
        queue_random(150, 255, 100, 50);
        drain();

        configure(0, 255, 1, 7, IDLE_BOTH);
        queue_random(120, 10, 80, 55);
        drain();

        // Long output hold-off while the sender keeps offering beats.
        configure(511, 30, 0, 2, IDLE_NONE);
        hold_req++;
        queue_random(150, 20, 50, 55);
        drain();

        configure(2, 0, 0, 300, IDLE_BOTH);
        queue_random(130, 255, 65535, 55);
        drain();

        configure(9, 100, 0, 1, IDLE_SENDER);
        queue_random(150, 30, 40, 55);
        drain();

        // One frame with zero delay: every timed beat ends a pass, so the
        // loop count climbs to its ceiling.
        configure(1, 255, 0, 1, IDLE_RECEIVER);
        beats_to_send.push_back(make_item(afs_pkg::OP_LOAD, 0, 0, 0, 0));
        beats_to_send.push_back(make_item(afs_pkg::OP_CTRL, 0,
                                          1 << afs_pkg::BTN_RESTART, 0, 0));
        queue_random(330, 0, 3, 90);
        drain();

        repeat (8) @(posedge clk);
        $display("Sent %0d beats and checked %0d results over %0d register settings.",
                 beats_in, results_out, phases_run);
        $display("Frame starts %0d, complete results %0d, highest loop count %0d.",
                 frames_seen, complete_seen, loops_peak);
        if (failures == 0 && status_due.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
